FILE: sv/tlp_pkg.sv
// ============================================================================
// tlp_pkg
// Shared types and codes of the telnet receive line parser.
// ============================================================================
package tlp_pkg;

    // result kinds, carried on m_tuser
    typedef enum logic [3:0] {
        KIND_ECHO      = 4'd0,
        KIND_OPTION    = 4'd1,
        KIND_LINE      = 4'd2,
        KIND_EOF       = 4'd3,
        KIND_NOT_READY = 4'd4,
        KIND_INTERRUPT = 4'd5,
        KIND_ABORT     = 4'd6,
        KIND_AYT       = 4'd7,
        KIND_REFUSED   = 4'd8
    } tlp_kind_t;

    // receive parser states
    typedef enum logic [2:0] {
        PS_NORMAL = 3'd0,
        PS_CR     = 3'd1,
        PS_IAC    = 3'd2,
        PS_WILL   = 3'd3,
        PS_WONT   = 3'd4,
        PS_DO     = 3'd5,
        PS_DONT   = 3'd6
    } tlp_pstate_t;

    // echo negotiation states; codes 5 to 7 can be written and freeze negotiation
    localparam logic [2:0] ES_SENT_DO   = 3'd0;
    localparam logic [2:0] ES_SENT_WILL = 3'd1;
    localparam logic [2:0] ES_SELF      = 3'd2;
    localparam logic [2:0] ES_OTHER     = 3'd3;
    localparam logic [2:0] ES_NONE      = 3'd4;

    // input item selector, carried on s_tuser
    localparam logic MODE_RX   = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_ECHO_START = 1'b0;

    // telnet command and option bytes
    localparam logic [7:0] CMD_IAC  = 8'hFF;
    localparam logic [7:0] CMD_DONT = 8'hFE;
    localparam logic [7:0] CMD_DO   = 8'hFD;
    localparam logic [7:0] CMD_WONT = 8'hFC;
    localparam logic [7:0] CMD_WILL = 8'hFB;
    localparam logic [7:0] CMD_EL   = 8'hF8;
    localparam logic [7:0] CMD_EC   = 8'hF7;
    localparam logic [7:0] CMD_AYT  = 8'hF6;
    localparam logic [7:0] CMD_AO   = 8'hF5;
    localparam logic [7:0] CMD_IP   = 8'hF4;
    localparam logic [7:0] OPT_ECHO = 8'h01;
    localparam logic [7:0] OPT_SGA  = 8'h03;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // result queue
    localparam int MAX_RES   = 6;
    localparam int RES_DEPTH = 8;
    localparam int RES_PTR_W = 3;
    localparam int RES_CNT_W = 4;
    localparam int RES_NUM_W = 3;

    typedef struct packed {
        tlp_kind_t  kind;
        logic [7:0] data_byte;
        logic       last;
        logic       echo_on;
        logic       sga_on;
    } tlp_entry_t;

    typedef struct packed {
        tlp_pstate_t parse_state;
        logic        line_complete;
        logic        eof_pending;
        logic [2:0]  echo_state;
        logic        echo_flag;
        logic        sga_flag;
        logic        sga_answered;
    } tlp_flags_t;

endpackage

FILE: sv/tlp_step.sv
// ============================================================================
// tlp_step
// Next-state and result logic for one input word of the line parser.
// ============================================================================
module tlp_step
    import tlp_pkg::*;
#(
    parameter int LINE_BYTES = 64,
    parameter int AW = $clog2(LINE_BYTES),
    parameter int CW = $clog2(LINE_BYTES + 1)
) (
    input  logic                   mode,
    input  logic [7:0]             rx_byte,
    input  tlp_flags_t             cur,
    input  logic [CW-1:0]          fill_count,
    input  logic [AW-1:0]          read_position,
    input  logic [7:0]             rd_byte,
    output tlp_flags_t             nxt,
    output logic [CW-1:0]          fill_next,
    output logic [AW-1:0]          rp_next,
    output logic                   wr_en,
    output logic [AW-1:0]          wr_addr,
    output logic [7:0]             wr_data,
    output logic                   wr2_en,
    output logic [AW-1:0]          wr2_addr,
    output logic [7:0]             wr2_data,
    output logic [RES_NUM_W-1:0]   res_cnt,
    output tlp_entry_t [MAX_RES-1:0] res
);

    localparam logic [CW:0] LB_EXT = (CW+1)'(LINE_BYTES);

    typedef struct packed {
        logic [2:0] state;
        logic       flag_wr;
        logic       flag_val;
        logic [1:0] cnt;
        logic [7:0] cmd0;
        logic [7:0] cmd1;
    } tlp_neg_t;

    function automatic tlp_neg_t negotiate(input logic [2:0] st, input logic [7:0] cmd);
        tlp_neg_t r;
        r.state    = st;
        r.flag_wr  = 1'b0;
        r.flag_val = 1'b0;
        r.cnt      = 2'd0;
        r.cmd0     = CMD_WILL;
        r.cmd1     = CMD_WILL;
        case (st)
            ES_SENT_DO:
            begin
                if (cmd == CMD_WILL) begin
                    r.state   = ES_OTHER;
                    r.flag_wr = 1'b1;
                end else if (cmd == CMD_WONT) begin
                    r.cnt   = 2'd1;
                    r.cmd0  = CMD_WILL;
                    r.state = ES_SENT_WILL;
                end else if (cmd == CMD_DO) begin
                    r.cnt  = 2'd1;
                    r.cmd0 = CMD_WONT;
                end
            end
            ES_SENT_WILL:
            begin
                if (cmd == CMD_DO) begin
                    r.state    = ES_SELF;
                    r.flag_wr  = 1'b1;
                    r.flag_val = 1'b1;
                end else if (cmd == CMD_DONT) begin
                    r.state   = ES_NONE;
                    r.flag_wr = 1'b1;
                end else if (cmd == CMD_WILL) begin
                    r.cnt  = 2'd1;
                    r.cmd0 = CMD_DONT;
                end
            end
            ES_SELF:
            begin
                if (cmd == CMD_DONT) begin
                    r.cnt     = 2'd1;
                    r.cmd0    = CMD_WONT;
                    r.state   = ES_NONE;
                    r.flag_wr = 1'b1;
                end else if (cmd == CMD_WILL) begin
                    r.cnt  = 2'd1;
                    r.cmd0 = CMD_DONT;
                end
            end
            ES_OTHER:
            begin
                if (cmd == CMD_WONT) begin
                    r.cnt   = 2'd2;
                    r.cmd0  = CMD_DONT;
                    r.cmd1  = CMD_WILL;
                    r.state = ES_SENT_WILL;
                end else if (cmd == CMD_DO) begin
                    r.cnt  = 2'd1;
                    r.cmd0 = CMD_WONT;
                end
            end
            ES_NONE:
            begin
                if (cmd == CMD_DO) begin
                    r.cnt      = 2'd1;
                    r.cmd0     = CMD_WILL;
                    r.state    = ES_SELF;
                    r.flag_wr  = 1'b1;
                    r.flag_val = 1'b1;
                end else if (cmd == CMD_WILL) begin
                    r.cnt  = 2'd1;
                    r.cmd0 = CMD_DONT;
                end
            end
            default:
            begin
                r.state = st;
            end
        endcase
        return r;
    endfunction

    logic [CW:0] sum0;
    logic [CW:0] sum1;

    // store positions behind the line, wrapped into the circular store
    always_comb
    begin
        sum0     = (CW+1)'(read_position) + (CW+1)'(fill_count);
        sum1     = sum0 + 1'b1;
        wr_addr  = (sum0 >= LB_EXT) ? AW'(sum0 - LB_EXT) : AW'(sum0);
        wr2_addr = (sum1 >= LB_EXT) ? AW'(sum1 - LB_EXT) : AW'(sum1);
    end

    always_comb
    begin
        tlp_neg_t     ng;
        logic [1:0]   st_cnt;
        logic [7:0]   st0;
        logic [7:0]   st1;
        logic         echo_en;
        logic [7:0]   echo_b;
        logic [1:0]   opt_cnt;
        logic [7:0]   opt_cmd0;
        logic [7:0]   opt_cmd1;
        logic         ev_en;
        tlp_kind_t    ev_kind;
        logic [7:0]   ev_byte;
        logic         ev_last;

        nxt       = cur;
        fill_next = fill_count;
        rp_next   = read_position;
        wr_en     = 1'b0;
        wr2_en    = 1'b0;
        wr_data   = rx_byte;
        wr2_data  = rx_byte;
        st_cnt    = 2'd0;
        st0       = rx_byte;
        st1       = rx_byte;
        echo_en   = 1'b0;
        echo_b    = rx_byte;
        opt_cnt   = 2'd0;
        opt_cmd0  = CMD_WILL;
        opt_cmd1  = CMD_WILL;
        ev_en     = 1'b0;
        ev_kind   = KIND_NOT_READY;
        ev_byte   = 8'h00;
        ev_last   = 1'b1;
        ng        = negotiate(cur.echo_state, CMD_WILL);

        if (mode == MODE_READ) begin
            ev_en = 1'b1;
            if (cur.line_complete && (fill_count != '0)) begin
                fill_next = fill_count - 1'b1;
                rp_next   = (read_position == AW'(LINE_BYTES - 1)) ? '0
                                                                   : read_position + 1'b1;
                if (fill_next == '0) begin
                    nxt.sga_answered  = 1'b0;
                    nxt.line_complete = cur.eof_pending;
                end
                ev_kind = KIND_LINE;
                ev_byte = rd_byte;
                ev_last = (fill_next == '0);
            end else if (cur.eof_pending) begin
                nxt.eof_pending   = 1'b0;
                nxt.line_complete = 1'b0;
                ev_kind           = KIND_EOF;
            end else begin
                // an empty finished line is simply dropped
                nxt.line_complete = 1'b0;
                ev_kind           = KIND_NOT_READY;
            end
        end else if (cur.line_complete) begin
            ev_en   = 1'b1;
            ev_kind = KIND_REFUSED;
            ev_byte = rx_byte;
        end else begin
            nxt.parse_state = PS_NORMAL;
            case (cur.parse_state)
                PS_CR:
                begin
                    if ((rx_byte == CH_NUL) || (rx_byte == CH_LF)) begin
                        st_cnt            = 2'd1;
                        nxt.line_complete = 1'b1;
                    end else begin
                        // bare CR: pad with NUL, keep the byte
                        st_cnt  = 2'd2;
                        st0     = CH_NUL;
                        echo_en = cur.echo_flag;
                    end
                end
                PS_IAC:
                begin
                    case (rx_byte)
                        CMD_WILL: nxt.parse_state = PS_WILL;
                        CMD_WONT: nxt.parse_state = PS_WONT;
                        CMD_DO:   nxt.parse_state = PS_DO;
                        CMD_DONT: nxt.parse_state = PS_DONT;
                        CMD_IP:
                        begin
                            ev_en   = 1'b1;
                            ev_kind = KIND_INTERRUPT;
                        end
                        CMD_AO:
                        begin
                            ev_en   = 1'b1;
                            ev_kind = KIND_ABORT;
                        end
                        CMD_AYT:
                        begin
                            ev_en   = 1'b1;
                            ev_kind = KIND_AYT;
                        end
                        CMD_EC:
                        begin
                            if (fill_count != '0) begin
                                fill_next = fill_count - 1'b1;
                            end
                        end
                        CMD_EL:   fill_next = '0;
                        default:  nxt.parse_state = PS_NORMAL;
                    endcase
                end
                PS_WILL:
                begin
                    if (rx_byte == OPT_SGA) begin
                        if (!cur.sga_answered) begin
                            nxt.sga_answered = 1'b1;
                            opt_cnt          = 2'd1;
                            opt_cmd0         = CMD_WILL;
                        end
                    end else if (rx_byte == OPT_ECHO) begin
                        ng       = negotiate(cur.echo_state, CMD_WILL);
                        opt_cnt  = ng.cnt;
                        opt_cmd0 = ng.cmd0;
                        opt_cmd1 = ng.cmd1;
                        nxt.echo_state = ng.state;
                        if (ng.flag_wr) begin
                            nxt.echo_flag = ng.flag_val;
                        end
                    end else begin
                        opt_cnt  = 2'd1;
                        opt_cmd0 = CMD_DONT;
                    end
                end
                PS_WONT, PS_DONT:
                begin
                    if (rx_byte == OPT_ECHO) begin
                        ng = negotiate(cur.echo_state,
                                       (cur.parse_state == PS_WONT) ? CMD_WONT : CMD_DONT);
                        opt_cnt  = ng.cnt;
                        opt_cmd0 = ng.cmd0;
                        opt_cmd1 = ng.cmd1;
                        nxt.echo_state = ng.state;
                        if (ng.flag_wr) begin
                            nxt.echo_flag = ng.flag_val;
                        end
                    end
                end
                PS_DO:
                begin
                    if (rx_byte == OPT_SGA) begin
                        opt_cnt      = 2'd1;
                        opt_cmd0     = CMD_WILL;
                        nxt.sga_flag = 1'b1;
                    end else if (rx_byte == OPT_ECHO) begin
                        ng       = negotiate(cur.echo_state, CMD_DO);
                        opt_cnt  = ng.cnt;
                        opt_cmd0 = ng.cmd0;
                        opt_cmd1 = ng.cmd1;
                        nxt.echo_state = ng.state;
                        if (ng.flag_wr) begin
                            nxt.echo_flag = ng.flag_val;
                        end
                    end else begin
                        opt_cnt  = 2'd1;
                        opt_cmd0 = CMD_WONT;
                    end
                end
                default:
                begin
                    case (rx_byte)
                        CH_CR:
                        begin
                            st_cnt          = 2'd1;
                            echo_en         = 1'b1;
                            nxt.parse_state = PS_CR;
                        end
                        CH_BS, CH_DEL:
                        begin
                            if (fill_count != '0) begin
                                fill_next = fill_count - 1'b1;
                                echo_en   = cur.echo_flag;
                            end
                        end
                        CH_LF:
                        begin
                            st_cnt            = 2'd1;
                            nxt.line_complete = 1'b1;
                        end
                        CH_EOT:
                        begin
                            nxt.eof_pending   = 1'b1;
                            nxt.line_complete = 1'b1;
                        end
                        CMD_IAC:  nxt.parse_state = PS_IAC;
                        default:
                        begin
                            if (rx_byte inside {[CH_SPACE:CH_TILDE]}) begin
                                st_cnt = 2'd1;
                            end
                            echo_en = cur.echo_flag;
                        end
                    endcase
                end
            endcase
        end

        // stores never share a step with a removal, so the old fill count is used
        if ((st_cnt != 2'd0) && (fill_count < CW'(LINE_BYTES))) begin
            wr_en     = 1'b1;
            wr_data   = st0;
            fill_next = fill_count + 1'b1;
        end
        if ((st_cnt == 2'd2) && (((CW+1)'(fill_count) + 1'b1) < LB_EXT)) begin
            wr2_en    = 1'b1;
            wr2_data  = st1;
            fill_next = fill_count + CW'(2);
        end

        for (int k = 0; k < MAX_RES; k++) begin
            res[k].kind      = KIND_ECHO;
            res[k].data_byte = 8'h00;
            res[k].last      = 1'b0;
            res[k].echo_on   = nxt.echo_flag;
            res[k].sga_on    = nxt.sga_flag;
        end
        res_cnt = '0;

        if (ev_en) begin
            res[0].kind      = ev_kind;
            res[0].data_byte = ev_byte;
            res_cnt          = RES_NUM_W'(1);
        end else if (echo_en) begin
            if ((echo_b == CH_BS) || (echo_b == CH_DEL) || (echo_b == CMD_EC)) begin
                res[0].data_byte = CH_BS;
                res[1].data_byte = CH_SPACE;
                res[2].data_byte = CH_BS;
                res_cnt          = RES_NUM_W'(3);
            end else if (echo_b == CH_CR) begin
                res[0].data_byte = CH_CR;
                res[1].data_byte = CH_LF;
                res_cnt          = RES_NUM_W'(2);
            end else if (echo_b inside {[CH_SPACE:CH_TILDE]}) begin
                res[0].data_byte = echo_b;
                res_cnt          = RES_NUM_W'(1);
            end
        end else if (opt_cnt != 2'd0) begin
            res[0].data_byte = CMD_IAC;
            res[1].data_byte = opt_cmd0;
            res[2].data_byte = rx_byte;
            res[3].data_byte = CMD_IAC;
            res[4].data_byte = opt_cmd1;
            res[5].data_byte = rx_byte;
            for (int k = 0; k < MAX_RES; k++) begin
                res[k].kind = KIND_OPTION;
            end
            res_cnt = (opt_cnt == 2'd2) ? RES_NUM_W'(6) : RES_NUM_W'(3);
        end

        if (mode == MODE_READ) begin
            res[0].last = ev_last;
        end else if (res_cnt != '0) begin
            res[res_cnt - 1'b1].last = 1'b1;
        end
    end

endmodule

FILE: sv/tlp_result_fifo.sv
// ============================================================================
// tlp_result_fifo
// Result queue: takes up to six words per cycle, hands out one per cycle when popped.
// ============================================================================
module tlp_result_fifo
    import tlp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [RES_NUM_W-1:0]     push_cnt,
    input  tlp_entry_t [MAX_RES-1:0] push_data,
    input  logic                     pop,
    output tlp_entry_t               head,
    output logic                     head_valid,
    output logic [RES_CNT_W-1:0]     level
);

    tlp_entry_t [RES_DEPTH-1:0] store_reg;
    logic [RES_PTR_W-1:0]       wr_ptr_reg;
    logic [RES_PTR_W-1:0]       wr_ptr_next;
    logic [RES_PTR_W-1:0]       rd_ptr_reg;
    logic [RES_PTR_W-1:0]       rd_ptr_next;
    logic [RES_CNT_W-1:0]       level_reg;
    logic [RES_CNT_W-1:0]       level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        level_next  = level_reg + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (RES_NUM_W'(k) < push_cnt) begin
                store_reg[wr_ptr_reg + RES_PTR_W'(k)] <= push_data[k];
            end
        end
    end

    assign head       = store_reg[rd_ptr_reg];
    assign head_valid = (level_reg != '0);
    assign level      = level_reg;

endmodule

FILE: sv/telnet_receive_line_parser_core.sv
// ============================================================================
// telnet_receive_line_parser_core
// Telnet receive parser: builds one input line, handles IAC commands and
// ECHO / Suppress-Go-Ahead negotiation, and hands the line out on request.
// An input word is one received byte (s_tuser 0) or one read request
// (s_tuser 1). It lands in an input register and is processed from there;
// its result words leave through the result queue. One input word is taken
// per cycle while processing does not stall; a CR followed by a byte other
// than NUL or LF stores two bytes and holds the input while the second byte
// is written, as the line store has a single write port. Each input word
// gives up to six result words, which wait in an eight-word queue; the word
// in the input register is processed only while that queue has room for six
// more. The line store has no reset and needs no clearing pass.
// ============================================================================
module telnet_receive_line_parser_core
    import tlp_pkg::*;
#(
    parameter int LINE_BYTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [8] echo_on, [9] sga_on, zero above
    output logic [3:0]  m_tuser,   // [3:0] kind
    output logic        m_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(LINE_BYTES);
    localparam int CW = $clog2(LINE_BYTES + 1);

    // input register
    logic          in_valid_reg;
    logic          in_valid_next;
    logic          in_mode_reg;
    logic [7:0]    in_byte_reg;

    // parser state
    tlp_flags_t    flags_reg;
    tlp_flags_t    flags_next;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic [AW-1:0] rp_reg;
    logic [AW-1:0] rp_next;
    logic [2:0]    echo_start_reg;

    // deferred second byte of a bare CR
    logic          pend_valid_reg;
    logic          pend_valid_next;
    logic [AW-1:0] pend_addr_reg;
    logic [7:0]    pend_data_reg;

    // line store
    logic [7:0]    line_mem [LINE_BYTES];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    // step outputs
    tlp_flags_t               st_flags;
    logic [CW-1:0]            st_fill;
    logic [AW-1:0]            st_rp;
    logic                     st_wr_en;
    logic [AW-1:0]            st_wr_addr;
    logic [7:0]               st_wr_data;
    logic                     st_wr2_en;
    logic [AW-1:0]            st_wr2_addr;
    logic [7:0]               st_wr2_data;
    logic [RES_NUM_W-1:0]     st_cnt;
    tlp_entry_t [MAX_RES-1:0] st_res;

    // result queue
    tlp_entry_t               q_head;
    logic                     q_valid;
    logic [RES_CNT_W-1:0]     q_level;
    logic [RES_NUM_W-1:0]     q_push_cnt;

    logic proc_fire;
    logic cfg_wr;

    assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == REG_ECHO_START);
    assign proc_fire = in_valid_reg && !pend_valid_reg
                       && (q_level <= RES_CNT_W'(RES_DEPTH - MAX_RES));
    assign s_tready  = !in_valid_reg || proc_fire;

    tlp_step #(
        .LINE_BYTES (LINE_BYTES),
        .AW         (AW),
        .CW         (CW)
    ) u_step (
        .mode          (in_mode_reg),
        .rx_byte       (in_byte_reg),
        .cur           (flags_reg),
        .fill_count    (fill_reg),
        .read_position (rp_reg),
        .rd_byte       (rd_data_reg),
        .nxt           (st_flags),
        .fill_next     (st_fill),
        .rp_next       (st_rp),
        .wr_en         (st_wr_en),
        .wr_addr       (st_wr_addr),
        .wr_data       (st_wr_data),
        .wr2_en        (st_wr2_en),
        .wr2_addr      (st_wr2_addr),
        .wr2_data      (st_wr2_data),
        .res_cnt       (st_cnt),
        .res           (st_res)
    );

    assign q_push_cnt = proc_fire ? st_cnt : '0;

    tlp_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (q_push_cnt),
        .push_data  (st_res),
        .pop        (m_tvalid && m_tready),
        .head       (q_head),
        .head_valid (q_valid),
        .level      (q_level)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end

        flags_next = flags_reg;
        fill_next  = fill_reg;
        rp_next    = rp_reg;
        if (cfg_wr) begin
            flags_next.echo_state = pwdata[2:0];
            flags_next.echo_flag  = (pwdata[2:0] == ES_SELF);
        end else if (proc_fire) begin
            flags_next = st_flags;
            fill_next  = st_fill;
            rp_next    = st_rp;
        end

        pend_valid_next = proc_fire && st_wr2_en;

        // the deferred byte owns the write port; processing waits for it
        mem_we    = pend_valid_reg || (proc_fire && st_wr_en);
        mem_waddr = pend_valid_reg ? pend_addr_reg : st_wr_addr;
        mem_wdata = pend_valid_reg ? pend_data_reg : st_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg   <= 1'b0;
            flags_reg      <= '{parse_state:   PS_NORMAL,
                                line_complete: 1'b0,
                                eof_pending:   1'b0,
                                echo_state:    ES_SENT_WILL,
                                echo_flag:     1'b0,
                                sga_flag:      1'b0,
                                sga_answered:  1'b0};
            fill_reg       <= '0;
            rp_reg         <= '0;
            pend_valid_reg <= 1'b0;
            echo_start_reg <= ES_SENT_WILL;
        end else begin
            in_valid_reg   <= in_valid_next;
            flags_reg      <= flags_next;
            fill_reg       <= fill_next;
            rp_reg         <= rp_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_wr) begin
                echo_start_reg <= pwdata[2:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (proc_fire && st_wr2_en) begin
            pend_addr_reg <= st_wr2_addr;
            pend_data_reg <= st_wr2_data;
        end
    end

    // line store; the read port follows the read position and sees this
    // cycle's write, so rd_data_reg always holds the byte at the head
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_we && (mem_waddr == rp_next)) begin
            rd_data_reg <= mem_wdata;
        end else begin
            rd_data_reg <= line_mem[rp_next];
        end
    end

    assign m_tvalid = q_valid;
    assign m_tdata  = {6'b0, q_head.sga_on, q_head.echo_on, q_head.data_byte};
    assign m_tuser  = q_head.kind;
    assign m_tlast  = q_head.last;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ECHO_START) ? {29'b0, echo_start_reg} : 32'b0;

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(LINE_BYTES))
        else $error("line fill count beyond store size");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

    a_pend_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |=> !pend_valid_reg)
        else $error("deferred store held longer than one cycle");

    a_refuse_keeps_line: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && (in_mode_reg == MODE_RX) && flags_reg.line_complete && !cfg_wr)
        |=> $stable(fill_reg) && $stable(rp_reg))
        else $error("refused byte changed the line");

endmodule
